FILE: hw/rtl/kbd_pkg.sv
`default_nettype none
package kbd_pkg;

   localparam int NUM_KEYS       = 5;
   localparam int MIN_BRIGHTNESS = 0;
   localparam int MS_PER_S       = 1000;
   localparam int QUEUE_DEPTH    = 4;
   localparam int DIV_STEPS      = 32;

   // 2^38 / 1000 rounded up: (ms * MS_RECIP) >> MS_RECIP_SHIFT is ms / 1000 for any 32-bit ms
   localparam logic [28:0] MS_RECIP       = 29'h1062_4DD3;
   localparam int          MS_RECIP_SHIFT = 38;

   localparam int KEY_IW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 16;

   // register indexes of the configuration port
   localparam logic [CSR_IW-1:0] CSR_PRESS_SCANS     = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_LOCKOUT_SCANS   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_DIM_CHECK_SCANS = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DIM_ENABLE      = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_BRIGHTNESS      = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_DIM_START_S     = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_DIM_STEP_S      = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_DIM_LEVEL_STEP  = 3'd7;

   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_LEVEL = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [2:0] key_index;
      logic [6:0] brightness;
      logic       last;
   } rsp_word_type;

endpackage
`default_nettype wire

FILE: hw/rtl/kbd_div.sv
`default_nettype none
module kbd_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [31:0]      quotient
);
   import kbd_pkg::*;

   localparam int CW = $clog2(DIV_STEPS + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] step_ff, step_in;
   logic [31:0]   quo_ff, quo_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   dvs_ff, dvs_in;
   logic [16:0]   trial;
   logic [16:0]   diff;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit a cycle, restoring
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/kbd_front.sv
`default_nettype none
module kbd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [kbd_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [kbd_pkg::CSR_DW-1:0]    csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [kbd_pkg::NUM_KEYS-1:0]  req_key_levels,
   input  wire logic [31:0]                   req_now_ms,
   output logic                               push_valid,
   output kbd_pkg::rsp_word_type              push_word,
   input  wire logic                          queue_full
);
   import kbd_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_KEYS    = 8'b0000_0010,
      ST_RESTORE = 8'b0000_0100,
      ST_DIMCHK  = 8'b0000_1000,
      ST_DIV1    = 8'b0001_0000,
      ST_DIV2    = 8'b0010_0000,
      ST_EVAL    = 8'b0100_0000,
      ST_FLUSH   = 8'b1000_0000
   } state_type;

   // configuration
   logic [7:0]  press_scans_ff, lockout_scans_ff;
   logic [15:0] dim_check_scans_ff, dim_start_s_ff, dim_step_s_ff;
   logic        dim_enable_ff;
   logic [6:0]  brightness_setting_ff, dim_level_step_ff;

   state_type             state_ff, state_in;
   logic [NUM_KEYS-1:0]   levels_ff, levels_in;
   logic [31:0]           now_ff, now_in;
   logic [KEY_IW-1:0]     key_ff, key_in;
   logic [NUM_KEYS-1:0]   locked_ff, locked_in;
   logic [7:0]            count_ff [NUM_KEYS];
   logic [7:0]            count_in [NUM_KEYS];
   logic [31:0]           last_press_ff, last_press_in;
   logic                  dimmed_ff, dimmed_in;
   logic [15:0]           check_ff, check_in;
   logic [6:0]            applied_ff, applied_in;
   logic [31:0]           idle_s_ff, idle_s_in;
   logic [39:0]           dec_ff, dec_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_word_type          pend_ff, pend_in;

   logic                  emit;
   rsp_word_type          emit_word;
   logic                  flush_push;
   logic                  emit_ok;
   logic                  div_start;
   logic [31:0]           div_dividend;
   logic [15:0]           div_divisor;
   logic                  div_busy;
   logic [31:0]           div_quotient;

   logic [7:0]            cnt_up, cnt_dn;
   logic [15:0]           check_up;
   logic                  last_key;
   logic [31:0]           idle_ms;
   logic [60:0]           idle_prod;
   logic [40:0]           dec_floor;
   logic                  over;
   logic [6:0]            new_level;

   kbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign emit_ok   = !pend_valid_ff || !queue_full;
   assign cnt_up    = count_ff[key_ff] + 8'd1;
   assign cnt_dn    = count_ff[key_ff] - 8'd1;
   assign check_up  = check_ff + 16'd1;
   assign last_key  = (key_ff == KEY_IW'(NUM_KEYS - 1));
   assign idle_ms   = now_ff - last_press_ff;
   // milliseconds to whole seconds by reciprocal multiply
   assign idle_prod = 61'(idle_ms) * 61'(MS_RECIP);
   assign dec_floor = {1'b0, dec_ff} + 41'(MIN_BRIGHTNESS);
   assign over      = dec_floor > 41'(brightness_setting_ff);
   assign new_level = over ? 7'(MIN_BRIGHTNESS) : (brightness_setting_ff - dec_ff[6:0]);

   always_comb begin
      state_in      = state_ff;
      levels_in     = levels_ff;
      now_in        = now_ff;
      key_in        = key_ff;
      locked_in     = locked_ff;
      count_in      = count_ff;
      last_press_in = last_press_ff;
      dimmed_in     = dimmed_ff;
      check_in      = check_ff;
      applied_in    = applied_ff;
      idle_s_in     = idle_s_ff;
      dec_in        = dec_ff;
      emit          = 1'b0;
      emit_word     = '0;
      flush_push    = 1'b0;
      div_start     = 1'b0;
      div_dividend  = idle_s_ff - 32'(dim_start_s_ff);
      div_divisor   = (dim_step_s_ff == 16'd0) ? 16'd1 : dim_step_s_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               levels_in = req_key_levels;
               now_in    = req_now_ms;
               key_in    = '0;
               state_in  = ST_KEYS;
            end
         end
         ST_KEYS: begin
            if (locked_ff[key_ff]) begin
               count_in[key_ff] = cnt_dn;
               if (cnt_dn == 8'd0) begin
                  locked_in[key_ff] = 1'b0;
               end
               key_in   = key_ff + 1'b1;
               state_in = last_key ? ST_DIMCHK : ST_KEYS;
            end else if (!levels_ff[key_ff]) begin
               if (cnt_up == press_scans_ff) begin
                  // press event: hold until the pending word can move on
                  if (emit_ok) begin
                     emit                = 1'b1;
                     emit_word.kind      = KIND_KEY;
                     emit_word.key_index = 3'(key_ff);
                     count_in[key_ff]    = lockout_scans_ff;
                     locked_in[key_ff]   = 1'b1;
                     key_in              = key_ff + 1'b1;
                     state_in            = last_key ? ST_DIMCHK : ST_KEYS;
                     if (dim_enable_ff) begin
                        last_press_in = now_ff;
                        if (dimmed_ff) begin
                           dimmed_in = 1'b0;
                           check_in  = '0;
                           if (applied_ff != brightness_setting_ff) begin
                              applied_in = brightness_setting_ff;
                              state_in   = ST_RESTORE;
                           end
                        end
                     end
                  end
               end else begin
                  count_in[key_ff] = cnt_up;
                  key_in           = key_ff + 1'b1;
                  state_in         = last_key ? ST_DIMCHK : ST_KEYS;
               end
            end else begin
               if (count_ff[key_ff] != 8'd0) begin
                  count_in[key_ff] = cnt_dn;
               end
               key_in   = key_ff + 1'b1;
               state_in = last_key ? ST_DIMCHK : ST_KEYS;
            end
         end
         ST_RESTORE: begin
            // key_ff already points past the key that restored
            if (emit_ok) begin
               emit                 = 1'b1;
               emit_word.kind       = KIND_LEVEL;
               emit_word.brightness = applied_ff;
               state_in = (key_ff == KEY_IW'(NUM_KEYS)) || (NUM_KEYS == 1) ||
                          (key_ff == '0) ? ST_DIMCHK : ST_KEYS;
            end
         end
         ST_DIMCHK: begin
            state_in = ST_FLUSH;
            if (dim_enable_ff) begin
               if (check_up > dim_check_scans_ff) begin
                  check_in  = '0;
                  idle_s_in = 32'(idle_prod >> MS_RECIP_SHIFT);
                  state_in  = ST_DIV1;
               end else begin
                  check_in = check_up;
               end
            end
         end
         ST_DIV1: begin
            if (idle_s_ff >= 32'(dim_start_s_ff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV2;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_DIV2: begin
            if (!div_busy) begin
               dec_in   = 40'(({1'b0, div_quotient} + 33'd1) * dim_level_step_ff);
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            dimmed_in = 1'b1;
            if (new_level == applied_ff) begin
               state_in = ST_FLUSH;
            end else if (emit_ok) begin
               emit                 = 1'b1;
               emit_word.kind       = KIND_LEVEL;
               emit_word.brightness = new_level;
               applied_in           = new_level;
               state_in             = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // release the held word marked as the scan's final one
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!queue_full) begin
               flush_push = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_in       = emit_word;
      end else if (flush_push) begin
         pend_valid_in = 1'b0;
      end
   end

   assign push_valid = (emit && pend_valid_ff) || flush_push;
   always_comb begin
      push_word      = pend_ff;
      push_word.last = flush_push;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         key_ff        <= '0;
         locked_ff     <= '0;
         last_press_ff <= '0;
         dimmed_ff     <= 1'b0;
         check_ff      <= '0;
         applied_ff    <= 7'd100;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         key_ff        <= key_in;
         locked_ff     <= locked_in;
         last_press_ff <= last_press_in;
         dimmed_ff     <= dimmed_in;
         check_ff      <= check_in;
         applied_ff    <= applied_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
      end
      levels_ff <= levels_in;
      now_ff    <= now_in;
      idle_s_ff <= idle_s_in;
      dec_ff    <= dec_in;
      pend_ff   <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_scans_ff        <= 8'd5;
         lockout_scans_ff      <= 8'd20;
         dim_check_scans_ff    <= 16'd100;
         dim_enable_ff         <= 1'b1;
         brightness_setting_ff <= 7'd50;
         dim_start_s_ff        <= 16'd30;
         dim_step_s_ff         <= 16'd5;
         dim_level_step_ff     <= 7'd10;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRESS_SCANS:     press_scans_ff        <= csr_wdata[7:0];
            CSR_LOCKOUT_SCANS:   lockout_scans_ff      <= csr_wdata[7:0];
            CSR_DIM_CHECK_SCANS: dim_check_scans_ff    <= csr_wdata;
            CSR_DIM_ENABLE:      dim_enable_ff         <= csr_wdata[0];
            CSR_BRIGHTNESS:      brightness_setting_ff <= csr_wdata[6:0];
            CSR_DIM_START_S:     dim_start_s_ff        <= csr_wdata;
            CSR_DIM_STEP_S:      dim_step_s_ff         <= csr_wdata;
            CSR_DIM_LEVEL_STEP:  dim_level_step_ff     <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/kbd_fifo.sv
`default_nettype none
module kbd_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  kbd_pkg::rsp_word_type      push_word,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       empty,
   output kbd_pkg::rsp_word_type      head
);
   import kbd_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   rsp_word_type  mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign full    = (fill_ff == CW'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/kbd_out.sv
`default_nettype none
module kbd_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  kbd_pkg::rsp_word_type  queue_head,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_kind,
   output logic [2:0]             rsp_key_index,
   output logic [6:0]             rsp_brightness,
   output logic                   rsp_last
);
   import kbd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   // advance when the output register is free or being taken
   assign queue_pop = !queue_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (queue_pop) begin
         valid_in = 1'b1;
         word_in  = queue_head;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = word_ff.kind;
   assign rsp_key_index  = word_ff.key_index;
   assign rsp_brightness = word_ff.brightness;
   assign rsp_last       = word_ff.last;

endmodule
`default_nettype wire

FILE: hw/rtl/key_debounce_with_backlight_dimming_top.sv
`default_nettype none
// channel   direction  handshake          word
// req       in         req_valid/stall    key_levels[NUM_KEYS], now_ms[32]
// rsp       out        rsp_valid/stall    kind, key_index[3], brightness[7], last
// csr       in         csr_write          csr_index[3], csr_wdata[16]
//
// A scan walks the keys one by one, then runs the dimming check and the flush; a press
// that restores the level adds a restore step. A due check turns idle ms into seconds by a
// reciprocal multiply and divides by the step size on a 32-step serial divider, which is
// skipped while idle time is below the start.
// Reset is synchronous and restores the register defaults; no clearing pass is needed.
// A stalled rsp holds the scan logic only once the four-word queue is full.
module key_debounce_with_backlight_dimming_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [kbd_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [kbd_pkg::CSR_DW-1:0]    csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [kbd_pkg::NUM_KEYS-1:0]  req_key_levels,
   input  wire logic [31:0]                   req_now_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_kind,
   output logic [2:0]                         rsp_key_index,
   output logic [6:0]                         rsp_brightness,
   output logic                               rsp_last
);
   import kbd_pkg::*;

   logic         push_valid;
   rsp_word_type push_word;
   logic         queue_full;
   logic         queue_pop;
   logic         queue_empty;
   rsp_word_type queue_head;

   kbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_levels (req_key_levels),
      .req_now_ms     (req_now_ms),
      .push_valid     (push_valid),
      .push_word      (push_word),
      .queue_full     (queue_full)
   );

   kbd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   kbd_out u_out (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_head     (queue_head),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_key_index  (rsp_key_index),
      .rsp_brightness (rsp_brightness),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire
